>>> design/pbs_pkg.sv
// Types, widths and codes for the plane/box straddle test.
// Shared by the channel interfaces and every design module; no dependencies.
`timescale 1ns / 1ps

package pbs_pkg;

   localparam int COORD_W = 32;
   localparam int NORM_W  = 18;
   localparam int OFFS_W  = 32;
   localparam int TOL_W   = 31;
   localparam int FRAC_W  = 16;
   localparam int PROD_W  = NORM_W + COORD_W;
   localparam int SUM_W   = PROD_W + 2;
   localparam int DIST_W  = SUM_W - FRAC_W + 1;
   localparam int CSR_W   = 32;
   localparam int CSR_IDX_W = 3;
   localparam int CORNERS = 8;

   localparam logic [1:0] OUT_NONE     = 2'd0;
   localparam logic [1:0] OUT_POSSIBLE = 2'd1;
   localparam logic [1:0] OUT_BAD      = 2'd2;
   localparam logic [1:0] OUT_INVALID  = 2'd3;

   localparam logic [1:0] BOX_OK  = 2'd0;
   localparam logic [1:0] BOX_BAD = 2'd1;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL_X = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL_Y = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL_Z = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TOL      = 3'd5;

   localparam logic signed [NORM_W-1:0] NORMAL_Z_RESET = 18'sd65536;
   localparam logic [TOL_W-1:0]         TOL_RESET      = 31'd66;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [NORM_W-1:0]  norm_type;
   typedef logic signed [PROD_W-1:0]  prod_word_type;

   typedef struct packed {
      coord_type  x_min;
      coord_type  y_min;
      coord_type  z_min;
      coord_type  x_max;
      coord_type  y_max;
      coord_type  z_max;
      logic [1:0] box_status;
      logic       cone_status;
   } box_type;

   typedef struct packed {
      prod_word_type px_lo;
      prod_word_type px_hi;
      prod_word_type py_lo;
      prod_word_type py_hi;
      prod_word_type pz_lo;
      prod_word_type pz_hi;
      logic          pre_hit;
      logic [1:0]    pre_outcome;
   } prod_type;

endpackage

>>> design/pbs_req_if.sv
// Box channel: valid/ready handshake carrying one bounding box and its status marks.
// Depends on pbs_pkg.
`timescale 1ns / 1ps

interface pbs_req_if;
   import pbs_pkg::*;

   logic       valid;
   logic       ready;
   coord_type  box_x_min;
   coord_type  box_y_min;
   coord_type  box_z_min;
   coord_type  box_x_max;
   coord_type  box_y_max;
   coord_type  box_z_max;
   logic [1:0] box_status;
   logic       cone_status;

   modport source (
      output valid, box_x_min, box_y_min, box_z_min, box_x_max, box_y_max, box_z_max,
             box_status, cone_status,
      input  ready
   );

   modport sink (
      input  valid, box_x_min, box_y_min, box_z_min, box_x_max, box_y_max, box_z_max,
             box_status, cone_status,
      output ready
   );

endinterface

>>> design/pbs_rsp_if.sv
// Outcome channel: valid/ready handshake carrying one 2-bit outcome code.
// Depends on pbs_pkg.
`timescale 1ns / 1ps

interface pbs_rsp_if;
   import pbs_pkg::*;

   logic       valid;
   logic       ready;
   logic [1:0] outcome;

   modport source (
      output valid, outcome,
      input  ready
   );

   modport sink (
      input  valid, outcome,
      output ready
   );

endinterface

>>> design/pbs_prod.sv
// Product stage: six normal-by-coordinate products and the status pre-decision.
// Depends on pbs_pkg.
`timescale 1ns / 1ps

module pbs_prod (
   input  logic              clock,
   input  logic              reset,
   input  logic              up_vld,
   input  pbs_pkg::box_type  up_box,
   output logic              up_rdy,
   input  logic              compute_mode,
   input  pbs_pkg::norm_type normal_x,
   input  pbs_pkg::norm_type normal_y,
   input  pbs_pkg::norm_type normal_z,
   output logic              dn_vld,
   input  logic              dn_rdy,
   output pbs_pkg::prod_type dn_prod
);
   import pbs_pkg::*;

   logic     vld_ff;
   prod_type prod_ff;
   prod_type prod_in;

   assign up_rdy = !vld_ff || dn_rdy;

   always_comb begin
      prod_in.px_lo = PROD_W'(normal_x) * PROD_W'(up_box.x_min);
      prod_in.px_hi = PROD_W'(normal_x) * PROD_W'(up_box.x_max);
      prod_in.py_lo = PROD_W'(normal_y) * PROD_W'(up_box.y_min);
      prod_in.py_hi = PROD_W'(normal_y) * PROD_W'(up_box.y_max);
      prod_in.pz_lo = PROD_W'(normal_z) * PROD_W'(up_box.z_min);
      prod_in.pz_hi = PROD_W'(normal_z) * PROD_W'(up_box.z_max);
      prod_in.pre_hit     = 1'b1;
      prod_in.pre_outcome = OUT_NONE;
      priority if (up_box.box_status == BOX_BAD) begin
         prod_in.pre_outcome = OUT_BAD;
      end else if (up_box.box_status != BOX_OK) begin
         prod_in.pre_outcome = OUT_INVALID;
      end else if (up_box.cone_status) begin
         prod_in.pre_outcome = OUT_BAD;
      end else if (compute_mode) begin
         prod_in.pre_outcome = OUT_POSSIBLE;
      end else begin
         prod_in.pre_hit = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (up_rdy) begin
         vld_ff <= up_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (up_rdy && up_vld) begin
         prod_ff <= prod_in;
      end
   end

   assign dn_vld  = vld_ff;
   assign dn_prod = prod_ff;

endmodule

>>> design/pbs_eval.sv
// Evaluation stage: corner distances to the plane, tolerance and sign checks, outcome register.
// Depends on pbs_pkg.
`timescale 1ns / 1ps

module pbs_eval (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        up_vld,
   input  pbs_pkg::prod_type           up_prod,
   output logic                        up_rdy,
   input  logic signed [pbs_pkg::OFFS_W-1:0] plane_offset,
   input  logic [pbs_pkg::TOL_W-1:0]   tolerance,
   output logic                        dn_vld,
   input  logic                        dn_rdy,
   output logic [1:0]                  dn_outcome
);
   import pbs_pkg::*;

   logic                vld_ff;
   logic [1:0]          outcome_ff;
   logic [1:0]          outcome_in;
   logic [CORNERS-1:0]  near;
   logic [CORNERS-1:0]  neg;

   assign up_rdy = !vld_ff || dn_rdy;

   for (genvar c = 0; c < CORNERS; c++) begin : g_corner
      logic signed [SUM_W-1:0]  sum;
      logic signed [DIST_W-1:0] gap;
      logic [DIST_W-1:0]        mag;

      always_comb begin
         sum  = SUM_W'((c & 1) != 0 ? up_prod.px_hi : up_prod.px_lo)
              + SUM_W'((c & 2) != 0 ? up_prod.py_hi : up_prod.py_lo)
              + SUM_W'((c & 4) != 0 ? up_prod.pz_hi : up_prod.pz_lo);
         gap  = DIST_W'($signed(sum[SUM_W-1:FRAC_W])) - DIST_W'(plane_offset);
         mag  = gap[DIST_W-1] ? DIST_W'(-gap) : DIST_W'(gap);
      end

      assign near[c] = mag <= DIST_W'(tolerance);
      assign neg[c]  = gap[DIST_W-1];
   end

   always_comb begin
      if (up_prod.pre_hit) begin
         outcome_in = up_prod.pre_outcome;
      end else if ((|near) || ((|neg) && !(&neg))) begin
         outcome_in = OUT_POSSIBLE;
      end else begin
         outcome_in = OUT_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (up_rdy) begin
         vld_ff <= up_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (up_rdy && up_vld) begin
         outcome_ff <= outcome_in;
      end
   end

   assign dn_vld     = vld_ff;
   assign dn_outcome = outcome_ff;

endmodule

>>> design/plane_box_straddle_test.sv
// Top level of the plane/box straddle test: input register, config registers, stage wiring.
// Depends on pbs_pkg, pbs_req_if, pbs_rsp_if, pbs_prod and pbs_eval.
//
//   channel  direction  handshake          payload
//   req      in         req.valid/ready    six Q16.16 box bounds, box_status, cone_status
//   rsp      out        rsp.valid/ready    outcome
//   csr      in         csr_we             csr_idx, csr_wdata
//
// One item per cycle sustained while rsp.ready stays high; an outcome passes the input
// register, the product register and the outcome register before it is valid on rsp.
// Back-pressure comes only from rsp.ready; every stage advances when the stage
// after it is empty or moving. Reset empties the pipeline and loads the
// configuration reset values.
`timescale 1ns / 1ps

module plane_box_straddle_test (
   input  logic                             clock,
   input  logic                             reset,
   pbs_req_if.sink                          req,
   pbs_rsp_if.source                        rsp,
   input  logic                             csr_we,
   input  logic [pbs_pkg::CSR_IDX_W-1:0]    csr_idx,
   input  logic [pbs_pkg::CSR_W-1:0]        csr_wdata
);
   import pbs_pkg::*;

   logic                     mode_ff;
   norm_type                 normal_x_ff;
   norm_type                 normal_y_ff;
   norm_type                 normal_z_ff;
   logic signed [OFFS_W-1:0] offset_ff;
   logic [TOL_W-1:0]         tol_ff;

   logic     a_vld_ff;
   box_type  box_ff;
   box_type  box_in;
   logic     a_rdy;
   logic     b_rdy;
   logic     b_vld;
   prod_type b_prod;
   logic     c_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= 1'b0;
         normal_x_ff <= '0;
         normal_y_ff <= '0;
         normal_z_ff <= NORMAL_Z_RESET;
         offset_ff   <= '0;
         tol_ff      <= TOL_RESET;
      end else if (csr_we) begin
         unique case (csr_idx)
            CSR_MODE:     mode_ff     <= csr_wdata[0];
            CSR_NORMAL_X: normal_x_ff <= csr_wdata[NORM_W-1:0];
            CSR_NORMAL_Y: normal_y_ff <= csr_wdata[NORM_W-1:0];
            CSR_NORMAL_Z: normal_z_ff <= csr_wdata[NORM_W-1:0];
            CSR_OFFSET:   offset_ff   <= csr_wdata[OFFS_W-1:0];
            CSR_TOL:      tol_ff      <= csr_wdata[TOL_W-1:0];
            default: ;
         endcase
      end
   end

   assign a_rdy     = !a_vld_ff || b_rdy;
   assign req.ready = a_rdy;

   always_comb begin
      box_in.x_min       = req.box_x_min;
      box_in.y_min       = req.box_y_min;
      box_in.z_min       = req.box_z_min;
      box_in.x_max       = req.box_x_max;
      box_in.y_max       = req.box_y_max;
      box_in.z_max       = req.box_z_max;
      box_in.box_status  = req.box_status;
      box_in.cone_status = req.cone_status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (a_rdy) begin
         a_vld_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (a_rdy && req.valid) begin
         box_ff <= box_in;
      end
   end

   pbs_prod u_prod (
      .clock        (clock),
      .reset        (reset),
      .up_vld       (a_vld_ff),
      .up_box       (box_ff),
      .up_rdy       (b_rdy),
      .compute_mode (mode_ff),
      .normal_x     (normal_x_ff),
      .normal_y     (normal_y_ff),
      .normal_z     (normal_z_ff),
      .dn_vld       (b_vld),
      .dn_rdy       (c_rdy),
      .dn_prod      (b_prod)
   );

   pbs_eval u_eval (
      .clock        (clock),
      .reset        (reset),
      .up_vld       (b_vld),
      .up_prod      (b_prod),
      .up_rdy       (c_rdy),
      .plane_offset (offset_ff),
      .tolerance    (tol_ff),
      .dn_vld       (rsp.valid),
      .dn_rdy       (rsp.ready),
      .dn_outcome   (rsp.outcome)
   );

`ifndef SYNTHESIS
   a_stall_only_from_rsp: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> rsp.valid)
      else $error("input stalled while result register empty");

   a_bad_box_decided: assert property (@(posedge clock) disable iff (reset)
      a_vld_ff && b_rdy && box_ff.box_status == BOX_BAD
      |=> b_prod.pre_hit && b_prod.pre_outcome == OUT_BAD)
      else $error("bad box not decided in product stage");

   a_pre_outcome_kept: assert property (@(posedge clock) disable iff (reset)
      b_vld && c_rdy && b_prod.pre_hit |=> rsp.valid && rsp.outcome == $past(b_prod.pre_outcome))
      else $error("status outcome lost in evaluation stage");
`endif

endmodule

>>> tb/plane_box_straddle_test_tb.sv
// Self-checking testbench for plane_box_straddle_test: directed boxes, then random phases
// under several plane settings and idle/stall mixes, each outcome checked against a typed expectation or a predictor.
// Depends on pbs_pkg, pbs_req_if, pbs_rsp_if and the plane_box_straddle_test RTL.
`timescale 1ns / 1ps

module plane_box_straddle_test_tb;
   import pbs_pkg::*;

   localparam int PIPE_DEPTH     = 3;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASES         = 8;
   localparam int PHASE_ITEMS    = 235;

   localparam logic [1:0] BOX_UNSET = 2'd2;
   localparam logic [1:0] BOX_SPARE = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   localparam coord_type C_MAX = 32'sh7FFF_FFFF;
   localparam coord_type C_MIN = 32'sh8000_0000;
   localparam coord_type ONE   = 32'sd65536;
   localparam logic TYPED     = 1'b1;
   localparam logic PREDICTED = 1'b0;

   // corner visiting order, 3 bits each: bit 0 x max, bit 1 y max, bit 2 z max
   localparam logic [23:0] CORNER_ORDER =
      {3'd6, 3'd5, 3'd7, 3'd3, 3'd4, 3'd2, 3'd1, 3'd0};

   typedef struct {
      box_type    b;
      logic       typed;
      logic [1:0] want;
   } probe_row_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_idx;
   logic [CSR_W-1:0]     csr_wdata;

   pbs_req_if req_ch ();
   pbs_rsp_if rsp_ch ();

   plane_box_straddle_test DUT (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   logic          cfg_mode   = 1'b0;
   norm_type      cfg_nx     = '0;
   norm_type      cfg_ny     = '0;
   norm_type      cfg_nz     = NORMAL_Z_RESET;
   coord_type     cfg_offset = '0;
   logic [TOL_W-1:0] cfg_tol = TOL_RESET;

   logic [1:0] outcome_q [$];
   int         send_idle_pct = 0;
   int         rsp_stall_pct = 0;
   int         fail_count    = 0;
   int         idle_run      = 0;

   function automatic logic [1:0] predict_outcome(box_type b);
      longint     lo [3];
      longint     hi [3];
      longint     first;
      longint     gap;
      longint     mag;
      logic [2:0] sel;
      logic       settled;
      logic [1:0] verdict;
      int         i;
      lo[0] = b.x_min;
      lo[1] = b.y_min;
      lo[2] = b.z_min;
      hi[0] = b.x_max;
      hi[1] = b.y_max;
      hi[2] = b.z_max;
      first = 0;
      settled = 1'b0;
      verdict = OUT_NONE;
      if (b.box_status == BOX_BAD) begin
         verdict = OUT_BAD;
      end else if (b.box_status != BOX_OK) begin
         verdict = OUT_INVALID;
      end else if (b.cone_status) begin
         verdict = OUT_BAD;
      end else if (cfg_mode) begin
         verdict = OUT_POSSIBLE;
      end else begin
         for (i = 0; i < CORNERS && !settled; i++) begin
            sel = CORNER_ORDER[3*i +: 3];
            gap = ((longint'(cfg_nx) * (sel[0] ? hi[0] : lo[0])
                  + longint'(cfg_ny) * (sel[1] ? hi[1] : lo[1])
                  + longint'(cfg_nz) * (sel[2] ? hi[2] : lo[2])) >>> FRAC_W)
                  - longint'(cfg_offset);
            mag = (gap < 0) ? -gap : gap;
            if (i == 0) begin
               first = gap;
            end else if ((first < 0 && gap >= 0) || (first > 0 && gap <= 0)) begin
               settled = 1'b1;
            end
            if (mag <= longint'(cfg_tol)) begin
               settled = 1'b1;
            end
         end
         if (settled) begin
            verdict = OUT_POSSIBLE;
         end
      end
      return verdict;
   endfunction

   function automatic probe_row_type make_row(coord_type x0, coord_type y0, coord_type z0,
                                              coord_type x1, coord_type y1, coord_type z1,
                                              logic [1:0] bs, logic cs, logic typed,
                                              logic [1:0] want);
      probe_row_type r;
      r.b = '{x0, y0, z0, x1, y1, z1, bs, cs};
      r.typed = typed;
      r.want = want;
      return r;
   endfunction

   function automatic box_type random_box();
      box_type   b;
      coord_type c [3];
      int        e [3];
      int        kind;
      int        k;
      kind = $urandom_range(99);
      for (k = 0; k < 3; k++) begin
         c[k] = $urandom_range(32'h0020_0000) - 32'h0010_0000;
         e[k] = $urandom_range(4096);
      end
      if (kind < 25) begin
         b = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 2'd0, 1'b0};
      end else if (kind < 75) begin
         b = '{c[0], c[1], c[2], c[0] + e[0], c[1] + e[1], c[2] + e[2], 2'd0, 1'b0};
         if ($urandom_range(9) == 0) begin
            b = '{b.x_max, b.y_max, b.z_max, b.x_min, b.y_min, b.z_min, 2'd0, 1'b0};
         end
      end else begin
         b = '{$urandom_range(512) - 256, $urandom_range(512) - 256,
               $urandom_range(512) - 256, $urandom_range(512) - 256,
               $urandom_range(512) - 256, $urandom_range(512) - 256, 2'd0, 1'b0};
      end
      if ($urandom_range(99) < 15) begin
         b.box_status = 2'($urandom_range(3));
         b.cone_status = 1'($urandom_range(1));
      end
      return b;
   endfunction

   // fill the unused upper bits of a register write with noise
   function automatic logic [CSR_W-1:0] pad_csr(int width, logic [CSR_W-1:0] value);
      logic [63:0] mask;
      mask = (64'd1 << width) - 64'd1;
      return (value & mask[CSR_W-1:0]) | ($urandom & ~mask[CSR_W-1:0]);
   endfunction

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] data);
      csr_we <= 1'b1;
      csr_idx <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_MODE:     cfg_mode = data[0];
         CSR_NORMAL_X: cfg_nx = data[NORM_W-1:0];
         CSR_NORMAL_Y: cfg_ny = data[NORM_W-1:0];
         CSR_NORMAL_Z: cfg_nz = data[NORM_W-1:0];
         CSR_OFFSET:   cfg_offset = data[OFFS_W-1:0];
         CSR_TOL:      cfg_tol = data[TOL_W-1:0];
         default: ;
      endcase
   endtask

   task automatic send_box(box_type b, logic [1:0] want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.box_x_min <= b.x_min;
      req_ch.box_y_min <= b.y_min;
      req_ch.box_z_min <= b.z_min;
      req_ch.box_x_max <= b.x_max;
      req_ch.box_y_max <= b.y_max;
      req_ch.box_z_max <= b.z_max;
      req_ch.box_status <= b.box_status;
      req_ch.cone_status <= b.cone_status;
      do @(posedge clock); while (!req_ch.ready);
      outcome_q.push_back(want);
   endtask

   task automatic drain();
      while (outcome_q.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 1) @(posedge clock);
   endtask

   always @(posedge clock) begin
      logic [1:0] want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (outcome_q.size() == 0) begin
            $error("outcome: expected none, got %0d", rsp_ch.outcome);
            fail_count++;
         end else begin
            want = outcome_q.pop_front();
            if (rsp_ch.outcome !== want) begin
               $error("outcome: expected %0d, got %0d", want, rsp_ch.outcome);
               fail_count++;
            end
         end
      end
      rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_run <= 0;
      end else if (idle_run >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_run <= idle_run + 1;
      end
   end

   initial begin
      probe_row_type    directed_rows [$];
      logic             mode_v;
      norm_type         nx_v;
      norm_type         ny_v;
      norm_type         nz_v;
      coord_type        offset_v;
      logic [TOL_W-1:0] tol_v;
      int               phase;
      int               n;

      reset = 1'b1;
      csr_we = 1'b0;
      csr_idx = '0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.box_x_min = '0;
      req_ch.box_y_min = '0;
      req_ch.box_z_min = '0;
      req_ch.box_x_max = '0;
      req_ch.box_y_max = '0;
      req_ch.box_z_max = '0;
      req_ch.box_status = '0;
      req_ch.cone_status = 1'b0;

      // reset plane: distance is z, tolerance 66
      directed_rows.push_back(make_row(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN,
                                       BOX_BAD, 1'b0, TYPED, OUT_BAD));
      directed_rows.push_back(make_row(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX,
                                       BOX_UNSET, 1'b1, TYPED, OUT_INVALID));
      directed_rows.push_back(make_row(0, 0, 0, 0, 0, 0, BOX_SPARE, 1'b0, TYPED, OUT_INVALID));
      directed_rows.push_back(make_row(0, 0, 0, 0, 0, 0, BOX_OK, 1'b1, TYPED, OUT_BAD));
      directed_rows.push_back(make_row(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN,
                                       BOX_BAD, 1'b1, TYPED, OUT_BAD));
      directed_rows.push_back(make_row(0, 0, 0, 0, 0, 0, BOX_OK, 1'b0, TYPED, OUT_POSSIBLE));
      directed_rows.push_back(make_row(0, 0, ONE, ONE, ONE, 2 * ONE,
                                       BOX_OK, 1'b0, TYPED, OUT_NONE));
      directed_rows.push_back(make_row(0, 0, -ONE, ONE, ONE, ONE,
                                       BOX_OK, 1'b0, TYPED, OUT_POSSIBLE));
      directed_rows.push_back(make_row(0, 0, 66, 0, 0, 1000, BOX_OK, 1'b0, TYPED, OUT_POSSIBLE));
      directed_rows.push_back(make_row(0, 0, 67, 0, 0, 1000, BOX_OK, 1'b0, TYPED, OUT_NONE));
      directed_rows.push_back(make_row(0, 0, -1000, 0, 0, -67, BOX_OK, 1'b0, TYPED, OUT_NONE));
      directed_rows.push_back(make_row(0, 0, -67, 0, 0, -66, BOX_OK, 1'b0, TYPED, OUT_POSSIBLE));
      directed_rows.push_back(make_row(0, 0, 2 * ONE, 0, 0, -2 * ONE,
                                       BOX_OK, 1'b0, TYPED, OUT_POSSIBLE));
      directed_rows.push_back(make_row(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX,
                                       BOX_OK, 1'b0, TYPED, OUT_NONE));
      directed_rows.push_back(make_row(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN,
                                       BOX_OK, 1'b0, TYPED, OUT_NONE));
      directed_rows.push_back(make_row(C_MIN, C_MIN, 100, C_MAX, C_MAX, 200,
                                       BOX_OK, 1'b0, TYPED, OUT_NONE));
      directed_rows.push_back(make_row(-5 * ONE, 0, 500, 3 * ONE, ONE, -500,
                                       BOX_OK, 1'b0, PREDICTED, OUT_NONE));
      directed_rows.push_back(make_row(C_MAX, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX,
                                       BOX_OK, 1'b0, PREDICTED, OUT_NONE));
      directed_rows.push_back(make_row(32'sh0000_FFFF, -1, 32'sh0000_FFFF, 1, 1, 32'sh0001_0001,
                                       BOX_OK, 1'b0, PREDICTED, OUT_NONE));

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         send_box(directed_rows[i].b, directed_rows[i].typed ? directed_rows[i].want
                                                             : predict_outcome(directed_rows[i].b));
      end
      req_ch.valid <= 1'b0;
      drain();

      for (phase = 0; phase < PHASES; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 69; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 69; end
            default: begin send_idle_pct = 32; rsp_stall_pct = 32; end
         endcase
         mode_v = 1'b0;
         nx_v = NORM_W'($urandom);
         ny_v = NORM_W'($urandom);
         nz_v = NORM_W'($urandom);
         offset_v = $urandom;
         tol_v = TOL_W'($urandom_range(65536));
         case (phase)
            0: begin nx_v = NORM_W'(ONE); ny_v = '0; nz_v = '0; offset_v = 0; tol_v = '0; end
            1: begin
               nx_v = -18'sd131072; ny_v = 18'sd131071; nz_v = -18'sd131072;
               offset_v = C_MIN; tol_v = 31'h7FFF_FFFF;
            end
            2: begin mode_v = 1'b1; tol_v = TOL_W'($urandom); end
            3: begin nx_v = '0; ny_v = NORM_W'(-ONE); nz_v = '0;
                     offset_v = $urandom_range(8192) - 4096;
                     tol_v = TOL_RESET; end
            4: begin nx_v = 18'sd131071; ny_v = 18'sd131071; nz_v = 18'sd131071;
                     offset_v = C_MAX; tol_v = TOL_W'($urandom_range(1024)); end
            6: begin nx_v = '0; ny_v = '0; nz_v = NORMAL_Z_RESET; offset_v = 0;
                     tol_v = TOL_RESET; end
            7: begin mode_v = 1'b1; offset_v = 0; tol_v = TOL_W'($urandom_range(256)); end
            default: ;
         endcase
         csr_write(CSR_MODE, pad_csr(1, mode_v));
         csr_write(CSR_NORMAL_X, pad_csr(NORM_W, nx_v));
         csr_write(CSR_NORMAL_Y, pad_csr(NORM_W, ny_v));
         csr_write(CSR_NORMAL_Z, pad_csr(NORM_W, nz_v));
         csr_write(CSR_OFFSET, offset_v);
         csr_write(CSR_TOL, pad_csr(TOL_W, tol_v));
         csr_write(CSR_SPARE_LO, $urandom);
         csr_write(CSR_SPARE_HI, $urandom);
         csr_we <= 1'b0;
         for (n = 0; n < PHASE_ITEMS; n++) begin
            box_type b;
            b = random_box();
            send_box(b, predict_outcome(b));
         end
         req_ch.valid <= 1'b0;
         drain();
      end

      repeat (2 * PIPE_DEPTH) @(posedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
